### rtl/core/kmauc_pkg.sv
// ----------------------------------------------------------------------------
// kmauc_pkg: shared definitions for the k-means assign/update/classify block
// Default sizes, action and result codes, register indexes and the command
// word that the front hands to the back through its queue.
// ----------------------------------------------------------------------------
package kmauc_pkg;

	// Default sizes for the top-level parameters.
	localparam int MAX_CLUSTERS_D  = 16;
	localparam int MAX_DIMENSION_D = 16;
	localparam int SAMPLE_BITS_D   = 16;
	localparam int COUNT_BITS_D    = 24;

	// Fixed field widths of the ports.
	localparam int AMOUNT_BITS    = 24;
	localparam int ID_BITS        = 4;
	localparam int CFG_BITS       = 5;
	localparam int CFG_INDEX_BITS = 2;

	// Depth of the command queue between front and back.
	localparam int QDEPTH = 4;

	// Input actions.
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_TRAIN = 2'd1;
	localparam logic [1:0] ACT_PASS  = 2'd2;
	localparam logic [1:0] ACT_CLASS = 2'd3;

	// Result kinds.
	localparam logic [1:0] KIND_ASSIGN = 2'd0;
	localparam logic [1:0] KIND_COUNT  = 2'd1;
	localparam logic [1:0] KIND_DIST   = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_CLUSTERS = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LENGTH   = 2'd1;

	// Decoded command word.
	typedef struct packed {
		logic [1:0] op;
		logic [3:0] csel;
		logic [3:0] dsel;
		logic       load_ok;
		logic       last;
	} cmd_t;

endpackage

### rtl/core/kmauc_front.sv
// ----------------------------------------------------------------------------
// kmauc_front: input word acceptance, decode and command queue
// Decodes each input word into a command and holds it in a short queue so
// that the input side keeps flowing while the back is busy.
// ----------------------------------------------------------------------------
module kmauc_front #(
	parameter int MAX_CLUSTERS  = kmauc_pkg::MAX_CLUSTERS_D,
	parameter int MAX_DIMENSION = kmauc_pkg::MAX_DIMENSION_D,
	parameter int SAMPLE_BITS   = kmauc_pkg::SAMPLE_BITS_D
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             action,
	input  logic [3:0]             cluster_sel,
	input  logic [3:0]             dim_sel,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   last_element,
	output logic                   q_valid,
	output kmauc_pkg::cmd_t        q_cmd,
	output logic [SAMPLE_BITS-1:0] q_sample,
	input  logic                   q_pop
);
	import kmauc_pkg::*;

	localparam int PW = $clog2(QDEPTH);
	localparam int FW = $clog2(QDEPTH + 1);

	cmd_t                   cmd_q [QDEPTH];
	logic [SAMPLE_BITS-1:0] smp_q [QDEPTH];
	logic [PW-1:0]          wr_ptr_q;
	logic [PW-1:0]          rd_ptr_q;
	logic [FW-1:0]          fill_q;
	cmd_t                   dec;
	logic                   push;
	logic                   pop;

	// Decode the incoming word.
	always_comb begin
		dec.op      = action;
		dec.csel    = cluster_sel;
		dec.dsel    = dim_sel;
		dec.load_ok = (32'(cluster_sel) < MAX_CLUSTERS) && (32'(dim_sel) < MAX_DIMENSION);
		dec.last    = last_element;
	end

	assign in_ready = (fill_q != FW'(QDEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (fill_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_cmd    = cmd_q[rd_ptr_q];
	assign q_sample = smp_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_ptr_q] <= dec;
			smp_q[wr_ptr_q] <= sample;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

endmodule

### rtl/core/kmauc_isqrt.sv
// ----------------------------------------------------------------------------
// kmauc_isqrt: iterative integer square root
// Produces floor(sqrt(operand)), one result bit per cycle.
// ----------------------------------------------------------------------------
module kmauc_isqrt #(
	parameter int IW = 37
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [IW-1:0]         operand,
	output logic                  busy,
	output logic [(IW+1)/2-1:0]   root
);
	localparam int RW = (IW + 1) / 2;
	localparam int VW = 2 * RW;
	localparam int CW = $clog2(RW + 1);

	logic [VW-1:0] v_q;
	logic [VW-1:0] r_q;
	logic [VW-1:0] bit_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [VW-1:0] trial;

	assign trial = r_q + bit_q;
	assign busy  = busy_q;
	assign root  = r_q[RW-1:0];

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(RW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// One digit per cycle: subtract the trial value when it fits.
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= VW'(operand);
			r_q   <= '0;
			bit_q <= VW'(1) << (VW - 2);
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

### rtl/core/kmauc_div.sv
// ----------------------------------------------------------------------------
// kmauc_div: iterative signed-by-unsigned divider
// Divides a signed sum by a nonzero count, truncating toward zero. The
// quotient is known to fit QW bits, so only QW steps are taken.
// ----------------------------------------------------------------------------
module kmauc_div #(
	parameter int SW = 40,
	parameter int CB = 24,
	parameter int QW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [SW-1:0] dividend,
	input  logic [CB-1:0]        divisor,
	output logic                 busy,
	output logic [QW-1:0]        quotient
);
	localparam int CW = $clog2(QW + 1);

	logic [SW-1:0] rem_q;
	logic [SW-1:0] dsh_q;
	logic [QW-1:0] q_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	assign busy     = busy_q;
	assign quotient = neg_q ? (~q_q + QW'(1)) : q_q;

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Restoring division on the magnitude, one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SW-1];
			rem_q <= dividend[SW-1] ? (~dividend + SW'(1)) : dividend;
			dsh_q <= SW'(divisor) << (QW - 1);
			q_q   <= '0;
		end else if (busy_q) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				q_q   <= {q_q[QW-2:0], 1'b1};
			end else begin
				q_q   <= {q_q[QW-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

endmodule

### rtl/core/kmauc_back.sv
// ----------------------------------------------------------------------------
// kmauc_back: command execution for the k-means block
// Owns the center, sum and count stores and the distance accumulators, and
// runs each queued command: center loads, frame elements with distance
// updates, nearest-center search, sum updates, end-of-pass division and
// result emission through an output register.
// ----------------------------------------------------------------------------
module kmauc_back #(
	parameter int MAX_CLUSTERS  = kmauc_pkg::MAX_CLUSTERS_D,
	parameter int MAX_DIMENSION = kmauc_pkg::MAX_DIMENSION_D,
	parameter int SAMPLE_BITS   = kmauc_pkg::SAMPLE_BITS_D,
	parameter int COUNT_BITS    = kmauc_pkg::COUNT_BITS_D
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       q_valid,
	input  kmauc_pkg::cmd_t                            q_cmd,
	input  logic [SAMPLE_BITS-1:0]                     q_sample,
	output logic                                       q_pop,
	input  logic [$clog2(MAX_CLUSTERS+1)-1:0]          nc,
	input  logic [$clog2(MAX_DIMENSION+1)-1:0]         nd,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic [1:0]                                 result_kind,
	output logic [kmauc_pkg::ID_BITS-1:0]              cluster_id,
	output logic [kmauc_pkg::AMOUNT_BITS-1:0]          amount,
	output logic [kmauc_pkg::ID_BITS-1:0]              best_cluster,
	output logic                                       last_result
);
	import kmauc_pkg::*;

	localparam int MC   = MAX_CLUSTERS;
	localparam int MD   = MAX_DIMENSION;
	localparam int SB   = SAMPLE_BITS;
	localparam int CB   = COUNT_BITS;
	localparam int CW   = (MC > 1) ? $clog2(MC) : 1;
	localparam int DW   = (MD > 1) ? $clog2(MD) : 1;
	localparam int NE   = MC * MD;
	localparam int AW   = (NE > 1) ? $clog2(NE) : 1;
	localparam int NCW  = $clog2(MC + 1);
	localparam int PW   = $clog2(MD + 1);
	localparam int KW   = $clog2(MC + 2);
	localparam int DCW  = $clog2(MD + 2);
	localparam int SQW  = 2 * SB + 1;
	localparam int DAW  = SQW + $clog2(MD);
	localparam int SW   = SB + CB;
	localparam int RW   = (DAW + 1) / 2;
	localparam int RXW  = (RW > AMOUNT_BITS) ? RW : AMOUNT_BITS;

	// Sequencer states.
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_ELEM   = 4'd1;
	localparam logic [3:0] S_ARG    = 4'd2;
	localparam logic [3:0] S_TCNT   = 4'd3;
	localparam logic [3:0] S_TSUM   = 4'd4;
	localparam logic [3:0] S_SQ     = 4'd5;
	localparam logic [3:0] S_SQW    = 4'd6;
	localparam logic [3:0] S_EMIT   = 4'd7;
	localparam logic [3:0] S_PRD    = 4'd8;
	localparam logic [3:0] S_PSTART = 4'd9;
	localparam logic [3:0] S_PDIV   = 4'd10;
	localparam logic [3:0] S_PEMIT  = 4'd11;

	logic [3:0]           state_q;
	logic [1:0]           op_q;
	logic                 last_q;
	logic signed [SB-1:0] x_q;
	logic [PW-1:0]        pos_q;
	logic [KW-1:0]        k_q;
	logic [DCW-1:0]       d_q;
	logic [CW-1:0]        best_q;
	logic [DAW-1:0]       bestd_q;

	logic [DAW-1:0]       acc_q  [MC];
	logic [CB-1:0]        cnt_q  [MC];
	logic [SB-1:0]        fbuf_q [MD];

	// Center and sum memories with per-entry valid bits.
	logic [SB-1:0]        cmem [NE];
	logic [NE-1:0]        cval_q;
	logic [SW-1:0]        smem [NE];
	logic [NE-1:0]        sval_q;

	// Distance pipeline.
	logic                 v_s1;
	logic [CW-1:0]        k_s1;
	logic [SB-1:0]        c_s1;
	logic                 cv_s1;
	logic                 v_s2;
	logic [CW-1:0]        k_s2;
	logic [SQW-1:0]       sq_s2;

	// Sum read stage.
	logic                 sv_s1;
	logic [DW-1:0]        sd_s1;
	logic [SW-1:0]        sdat_s1;
	logic                 svl_s1;

	// Output register.
	logic                 out_valid_q;
	logic [1:0]           kind_q;
	logic [ID_BITS-1:0]   id_q;
	logic [AMOUNT_BITS-1:0] amount_q;
	logic [ID_BITS-1:0]   best_out_q;
	logic                 last_out_q;

	logic                 issue;
	logic                 sissue;
	logic [AW-1:0]        crd_addr;
	logic                 cwr_en;
	logic [AW-1:0]        cwr_addr;
	logic [SB-1:0]        cwr_data;
	logic [AW-1:0]        srd_addr;
	logic                 swr_en;
	logic [AW-1:0]        swr_addr;
	logic [SW-1:0]        swr_data;
	logic                 pop;
	logic                 abandon;
	logic                 out_free;
	logic                 emit_done;
	logic                 k_is_last;
	logic                 d_is_last;
	logic [CW-1:0]        kc;
	logic [SB-1:0]        c_eff;
	logic signed [SB:0]   diff;
	logic signed [2*SB+1:0] prod;
	logic                 sq_start;
	logic                 sq_busy;
	logic [RW-1:0]        sq_root;
	logic [RXW-1:0]       root_x;
	logic [AMOUNT_BITS-1:0] root_sat;
	logic                 dv_start;
	logic                 dv_busy;
	logic [SB-1:0]        dv_quot;
	logic signed [SW-1:0] dv_dividend;

	assign kc        = k_q[CW-1:0];
	assign out_free  = !out_valid_q || out_ready;
	assign k_is_last = (k_q + KW'(1)) == KW'(nc);
	assign d_is_last = (d_q + DCW'(1)) == DCW'(nd);
	assign pop       = (state_q == S_IDLE) && q_valid;
	assign q_pop     = pop;
	assign emit_done = (state_q == S_EMIT) && out_free && ((op_q == ACT_TRAIN) || k_is_last);
	assign abandon   = (pop && ((q_cmd.op == ACT_LOAD) || (q_cmd.op == ACT_PASS))) || emit_done;

	// Distance update: difference, square, then accumulate.
	assign issue  = (state_q == S_ELEM) && (32'(k_q) < MC);
	assign crd_addr = AW'(AW'(kc) * AW'(MD) + AW'(pos_q));
	assign c_eff  = cv_s1 ? c_s1 : '0;
	assign diff   = $signed({x_q[SB-1], x_q}) - $signed({c_eff[SB-1], c_eff});
	assign prod   = diff * diff;

	// Sum memory addressing for training updates and end of pass.
	assign sissue   = (state_q == S_TSUM) && (32'(d_q) < 32'(nd));
	assign srd_addr = (state_q == S_TSUM) ?
		AW'(AW'(best_q) * AW'(MD) + AW'(d_q)) : AW'(AW'(kc) * AW'(MD) + AW'(d_q));
	assign swr_en   = (state_q == S_TSUM) && sv_s1;
	assign swr_addr = AW'(AW'(best_q) * AW'(MD) + AW'(sd_s1));
	assign swr_data = (svl_s1 ? sdat_s1 : '0) + SW'($signed(fbuf_q[sd_s1]));

	// Center writes from loads, from end-of-pass division and zeros for empty clusters.
	always_comb begin
		cwr_en   = 1'b0;
		cwr_addr = AW'(AW'(kc) * AW'(MD) + AW'(d_q));
		cwr_data = '0;
		if (pop && (q_cmd.op == ACT_LOAD) && q_cmd.load_ok) begin
			cwr_en   = 1'b1;
			cwr_addr = AW'(AW'(CW'(q_cmd.csel)) * AW'(MD) + AW'(DW'(q_cmd.dsel)));
			cwr_data = q_sample;
		end else if ((state_q == S_PRD) && (cnt_q[kc] == '0)) begin
			cwr_en = 1'b1;
		end else if ((state_q == S_PDIV) && !dv_busy) begin
			cwr_en   = 1'b1;
			cwr_data = dv_quot;
		end
	end

	// Square root and divider units.
	assign sq_start    = (state_q == S_SQ);
	assign dv_start    = (state_q == S_PSTART);
	assign dv_dividend = svl_s1 ? $signed(sdat_s1) : '0;

	kmauc_isqrt #(.IW(DAW)) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.operand (acc_q[kc]),
		.busy    (sq_busy),
		.root    (sq_root)
	);

	kmauc_div #(.SW(SW), .CB(CB), .QW(SB)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (dv_dividend),
		.divisor  (cnt_q[kc]),
		.busy     (dv_busy),
		.quotient (dv_quot)
	);

	assign root_x   = RXW'(sq_root);
	assign root_sat = (root_x > RXW'({AMOUNT_BITS{1'b1}})) ? '1 : root_x[AMOUNT_BITS-1:0];

	// Memory arrays.
	always_ff @(posedge clk) begin
		if (cwr_en) begin
			cmem[cwr_addr] <= cwr_data;
		end
		c_s1 <= cmem[crd_addr];
		if (swr_en) begin
			smem[swr_addr] <= swr_data;
		end
		sdat_s1 <= smem[srd_addr];
		sd_s1   <= DW'(d_q);
		k_s1    <= kc;
		k_s2    <= k_s1;
		sq_s2   <= prod[SQW-1:0];
	end

	// Valid bits and pipeline valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cval_q <= '0;
			sval_q <= '0;
			cv_s1  <= 1'b0;
			svl_s1 <= 1'b0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			sv_s1  <= 1'b0;
		end else begin
			cv_s1  <= cval_q[crd_addr];
			svl_s1 <= sval_q[srd_addr];
			v_s1   <= issue;
			v_s2   <= v_s1;
			sv_s1  <= sissue;
			if (cwr_en) begin
				cval_q[cwr_addr] <= 1'b1;
			end
			if ((state_q == S_PEMIT) && out_free && k_is_last) begin
				sval_q <= '0;
			end else if (swr_en) begin
				sval_q[swr_addr] <= 1'b1;
			end
		end
	end

	// Distance accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MC; i++) begin
				acc_q[i] <= '0;
			end
		end else if (abandon) begin
			for (int i = 0; i < MC; i++) begin
				acc_q[i] <= '0;
			end
		end else if (v_s2) begin
			acc_q[k_s2] <= acc_q[k_s2] + DAW'(sq_s2);
		end
	end

	// Member counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MC; i++) begin
				cnt_q[i] <= '0;
			end
		end else if ((state_q == S_PEMIT) && out_free && k_is_last) begin
			for (int i = 0; i < MC; i++) begin
				cnt_q[i] <= '0;
			end
		end else if ((state_q == S_TCNT) && !(&cnt_q[best_q])) begin
			cnt_q[best_q] <= cnt_q[best_q] + CB'(1);
		end
	end

	// Frame buffer takes the element when its distance pass ends.
	always_ff @(posedge clk) begin
		if ((state_q == S_ELEM) && (k_q == KW'(MC + 1))) begin
			fbuf_q[pos_q[DW-1:0]] <= x_q;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_EMIT || state_q == S_PEMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_EMIT) && out_free) begin
			kind_q     <= (op_q == ACT_TRAIN) ? KIND_ASSIGN : KIND_DIST;
			id_q       <= ID_BITS'(kc);
			amount_q   <= root_sat;
			best_out_q <= ID_BITS'(best_q);
			last_out_q <= (op_q == ACT_TRAIN) || k_is_last;
		end else if ((state_q == S_PEMIT) && out_free) begin
			kind_q     <= KIND_COUNT;
			id_q       <= ID_BITS'(kc);
			amount_q   <= AMOUNT_BITS'(cnt_q[kc]);
			best_out_q <= '0;
			last_out_q <= k_is_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = kind_q;
	assign cluster_id   = id_q;
	assign amount       = amount_q;
	assign best_cluster = best_out_q;
	assign last_result  = last_out_q;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= ACT_LOAD;
			last_q  <= 1'b0;
			x_q     <= '0;
			pos_q   <= '0;
			k_q     <= '0;
			d_q     <= '0;
			best_q  <= '0;
			bestd_q <= '0;
		end else begin
			if (abandon) begin
				pos_q <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						op_q   <= q_cmd.op;
						last_q <= q_cmd.last;
						x_q    <= $signed(q_sample);
						k_q    <= '0;
						d_q    <= '0;
						if (q_cmd.op == ACT_PASS) begin
							state_q <= S_PRD;
						end else if (q_cmd.op != ACT_LOAD) begin
							if (pos_q < nd) begin
								state_q <= S_ELEM;
							end else if (q_cmd.last) begin
								state_q <= S_ARG;
							end
						end
					end
				end
				S_ELEM: begin
					if (k_q == KW'(MC + 1)) begin
						pos_q <= pos_q + PW'(1);
						k_q   <= '0;
						if (last_q && ((PW + 1)'(pos_q) + (PW + 1)'(1) < (PW + 1)'(nd))) begin
							x_q <= '0;
						end else if (last_q) begin
							state_q <= S_ARG;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				S_ARG: begin
					if ((k_q == '0) || (acc_q[kc] < bestd_q)) begin
						best_q  <= kc;
						bestd_q <= acc_q[kc];
					end
					if (k_is_last) begin
						k_q     <= '0;
						state_q <= (op_q == ACT_TRAIN) ? S_TCNT : S_SQ;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				S_TCNT: begin
					k_q <= KW'(best_q);
					d_q <= '0;
					state_q <= (&cnt_q[best_q]) ? S_SQ : S_TSUM;
				end
				S_TSUM: begin
					if (d_q == DCW'(nd)) begin
						k_q     <= KW'(best_q);
						state_q <= S_SQ;
					end else begin
						d_q <= d_q + DCW'(1);
					end
				end
				S_SQ: begin
					state_q <= S_SQW;
				end
				S_SQW: begin
					if (!sq_busy) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						if (emit_done) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + KW'(1);
							state_q <= S_SQ;
						end
					end
				end
				S_PRD: begin
					if (cnt_q[kc] == '0) begin
						if (d_is_last) begin
							state_q <= S_PEMIT;
						end else begin
							d_q <= d_q + DCW'(1);
						end
					end else begin
						state_q <= S_PSTART;
					end
				end
				S_PSTART: begin
					state_q <= S_PDIV;
				end
				S_PDIV: begin
					if (!dv_busy) begin
						if (d_is_last) begin
							state_q <= S_PEMIT;
						end else begin
							d_q     <= d_q + DCW'(1);
							state_q <= S_PRD;
						end
					end
				end
				S_PEMIT: begin
					if (out_free) begin
						d_q <= '0;
						if (k_is_last) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + KW'(1);
							state_q <= S_PRD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/core/kmauc_top_cfg_unused.sv
// ----------------------------------------------------------------------------
// kmauc_cfg: configuration registers
// Holds the cluster count and vector length and clamps them to the ranges
// that the datapath supports.
// ----------------------------------------------------------------------------
module kmauc_cfg #(
	parameter int MAX_CLUSTERS  = kmauc_pkg::MAX_CLUSTERS_D,
	parameter int MAX_DIMENSION = kmauc_pkg::MAX_DIMENSION_D
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [kmauc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [kmauc_pkg::CFG_BITS-1:0]         cfg_data,
	output logic [$clog2(MAX_CLUSTERS+1)-1:0]      nc,
	output logic [$clog2(MAX_DIMENSION+1)-1:0]     nd
);
	import kmauc_pkg::*;

	localparam int NCW = $clog2(MAX_CLUSTERS + 1);
	localparam int PW  = $clog2(MAX_DIMENSION + 1);

	logic [CFG_BITS-1:0] cc_q;
	logic [CFG_BITS-1:0] vl_q;

	assign cfg_ready = 1'b1;

	// Register writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= CFG_BITS'(1);
			vl_q <= CFG_BITS'(1);
		end else if (cfg_valid) begin
			if (cfg_index == REG_CLUSTERS) begin
				cc_q <= cfg_data;
			end else if (cfg_index == REG_LENGTH) begin
				vl_q <= cfg_data;
			end
		end
	end

	// Clamp to one through the maximum.
	assign nc = (cc_q == '0) ? NCW'(1) :
		(32'(cc_q) > MAX_CLUSTERS) ? NCW'(MAX_CLUSTERS) : NCW'(cc_q);
	assign nd = (vl_q == '0) ? PW'(1) :
		(32'(vl_q) > MAX_DIMENSION) ? PW'(MAX_DIMENSION) : PW'(vl_q);

endmodule

### rtl/core/kmeans_assign_update_classify.sv
// ----------------------------------------------------------------------------
// kmeans_assign_update_classify: k-means assign, update and classify engine
// Loads cluster centers, assigns training frames to the nearest center,
// updates centers at end of pass and reports classify distances.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    action, cluster_sel, dim_sel, sample,
//                                   last_element
//   out      out_valid / out_ready  result_kind, cluster_id, amount,
//                                   best_cluster, last_result
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A word leaves the queue when the back is idle; an element then passes every center through
// the shared squaring multiplier, as does each missing element of a short frame. A last
// element adds a nearest-center search, a count and sum update for training, and a square
// root for each reported distance. End of pass divides each element sum of a nonempty
// cluster by its count, sets the centers of an empty one to zero and reports one count per
// cluster. A four-word queue and one output register absorb stalls; reset clears counts and
// distances, and stores via valid bits.
// ----------------------------------------------------------------------------
module kmeans_assign_update_classify #(
	parameter int MAX_CLUSTERS  = kmauc_pkg::MAX_CLUSTERS_D,
	parameter int MAX_DIMENSION = kmauc_pkg::MAX_DIMENSION_D,
	parameter int SAMPLE_BITS   = kmauc_pkg::SAMPLE_BITS_D,
	parameter int COUNT_BITS    = kmauc_pkg::COUNT_BITS_D
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           action,
	input  logic [3:0]                           cluster_sel,
	input  logic [3:0]                           dim_sel,
	input  logic [SAMPLE_BITS-1:0]               sample,
	input  logic                                 last_element,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [1:0]                           result_kind,
	output logic [kmauc_pkg::ID_BITS-1:0]        cluster_id,
	output logic [kmauc_pkg::AMOUNT_BITS-1:0]    amount,
	output logic [kmauc_pkg::ID_BITS-1:0]        best_cluster,
	output logic                                 last_result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [kmauc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [kmauc_pkg::CFG_BITS-1:0]       cfg_data
);
	import kmauc_pkg::*;

	localparam int NCW = $clog2(MAX_CLUSTERS + 1);
	localparam int PW  = $clog2(MAX_DIMENSION + 1);

	logic                   q_valid;
	cmd_t                   q_cmd;
	logic [SAMPLE_BITS-1:0] q_sample;
	logic                   q_pop;
	logic [NCW-1:0]         nc;
	logic [PW-1:0]          nd;

	kmauc_cfg #(
		.MAX_CLUSTERS  (MAX_CLUSTERS),
		.MAX_DIMENSION (MAX_DIMENSION)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.nc        (nc),
		.nd        (nd)
	);

	kmauc_front #(
		.MAX_CLUSTERS  (MAX_CLUSTERS),
		.MAX_DIMENSION (MAX_DIMENSION),
		.SAMPLE_BITS   (SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.cluster_sel  (cluster_sel),
		.dim_sel      (dim_sel),
		.sample       (sample),
		.last_element (last_element),
		.q_valid      (q_valid),
		.q_cmd        (q_cmd),
		.q_sample     (q_sample),
		.q_pop        (q_pop)
	);

	kmauc_back #(
		.MAX_CLUSTERS  (MAX_CLUSTERS),
		.MAX_DIMENSION (MAX_DIMENSION),
		.SAMPLE_BITS   (SAMPLE_BITS),
		.COUNT_BITS    (COUNT_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_cmd        (q_cmd),
		.q_sample     (q_sample),
		.q_pop        (q_pop),
		.nc           (nc),
		.nd           (nd),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.cluster_id   (cluster_id),
		.amount       (amount),
		.best_cluster (best_cluster),
		.last_result  (last_result)
	);

endmodule

### test/kmauc_checker.sv
// ----------------------------------------------------------------------------
// kmauc_checker: result predictor and scoreboard for the k-means engine
// Watches the configuration, input and output channels. It keeps its own
// copy of the center table, sums, counts and frame distances, predicts the
// words that each accepted input word causes, and compares every accepted
// output word with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module kmauc_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic [1:0]                           action,
	input  logic [3:0]                           cluster_sel,
	input  logic [3:0]                           dim_sel,
	input  logic [15:0]                          sample,
	input  logic                                 last_element,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic [1:0]                           result_kind,
	input  logic [kmauc_pkg::ID_BITS-1:0]        cluster_id,
	input  logic [kmauc_pkg::AMOUNT_BITS-1:0]    amount,
	input  logic [kmauc_pkg::ID_BITS-1:0]        best_cluster,
	input  logic                                 last_result,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [kmauc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [kmauc_pkg::CFG_BITS-1:0]       cfg_data,
	output int                                   errors,
	output int                                   pending,
	output int                                   words_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import kmauc_pkg::*;

	localparam int NCL = 16;
	localparam int NDIM = 16;
	localparam longint unsigned COUNT_TOP = 64'hFF_FFFF;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  id;
		logic [23:0] amt;
		logic [3:0]  best;
		logic        last;
	} result_t;

	result_t expected_words[$];

	longint          centers [NCL*NDIM];
	longint          sums    [NCL*NDIM];
	longint unsigned members [NCL];
	longint          frame_elem [NDIM];
	longint unsigned sq_dist [NCL];
	int              pos;
	logic [4:0]      clusters_reg, length_reg;

	function automatic int used_clusters();
		if (clusters_reg < 1) return 1;
		if (clusters_reg > NCL) return NCL;
		return int'(clusters_reg);
	endfunction

	function automatic int used_dims();
		if (length_reg < 1) return 1;
		if (length_reg > NDIM) return NDIM;
		return int'(length_reg);
	endfunction

	// Floor of the square root, saturated to the amount field.
	function automatic logic [23:0] root_amount(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return (r > 64'hFF_FFFF) ? 24'hFF_FFFF : r[23:0];
	endfunction

	function automatic void clear_frame();
		pos = 0;
		foreach (sq_dist[k]) sq_dist[k] = 0;
	endfunction

	// Buffer one element and accumulate its squared distance to every center.
	function automatic void add_element(longint x);
		longint d;
		longint unsigned m, s;
		if (pos >= used_dims()) return;
		frame_elem[pos] = x;
		for (int k = 0; k < NCL; k++) begin
			d = x - centers[k*NDIM + pos];
			m = (d < 0) ? -d : d;
			s = sq_dist[k] + m*m;
			sq_dist[k] = (s < m*m) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
		end
		pos++;
	endfunction

	function automatic void push_word(logic [1:0] kind, int id, logic [23:0] amt,
			int best, bit last);
		result_t w;
		w.kind = kind;
		w.id = id[3:0];
		w.amt = amt;
		w.best = best[3:0];
		w.last = last;
		expected_words = {expected_words, w};
	endfunction

	// Predict the result words of one accepted input word.
	function automatic void predict_word(logic [1:0] act, logic [3:0] cs, logic [3:0] ds,
			logic signed [15:0] smp, logic lst);
		int nc, nd, best;
		nc = used_clusters();
		nd = used_dims();
		if (act == ACT_LOAD) begin
			clear_frame();
			centers[cs*NDIM + ds] = smp;
		end else if (act == ACT_PASS) begin
			clear_frame();
			for (int k = 0; k < nc; k++) begin
				for (int d = 0; d < nd; d++)
					centers[k*NDIM + d] = (members[k] != 0) ?
						sums[k*NDIM + d] / longint'(members[k]) : 0;
				push_word(KIND_COUNT, k, members[k][23:0], 0, k + 1 == nc);
			end
			foreach (sums[i]) sums[i] = 0;
			foreach (members[k]) members[k] = 0;
		end else begin
			add_element(smp);
			if (!lst) return;
			while (pos < nd) add_element(0);
			best = 0;
			for (int k = 1; k < nc; k++)
				if (sq_dist[k] < sq_dist[best]) best = k;
			if (act == ACT_TRAIN) begin
				if (members[best] < COUNT_TOP) begin
					members[best]++;
					for (int d = 0; d < nd; d++)
						sums[best*NDIM + d] += frame_elem[d];
				end
				push_word(KIND_ASSIGN, best, root_amount(sq_dist[best]), best, 1);
			end else begin
				for (int k = 0; k < nc; k++)
					push_word(KIND_DIST, k, root_amount(sq_dist[k]), best, k + 1 == nc);
			end
			clear_frame();
		end
	endfunction

	assign pending = expected_words.size();

	// Sample all three channels at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			expected_words.delete();
			foreach (centers[i]) centers[i] = 0;
			foreach (sums[i]) sums[i] = 0;
			foreach (members[k]) members[k] = 0;
			foreach (frame_elem[i]) frame_elem[i] = 0;
			clear_frame();
			clusters_reg = 1;
			length_reg = 1;
			errors = 0;
			words_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{result_kind, cluster_id, amount, best_cluster, last_result};
				words_seen++;
				if (expected_words.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected output word kind %0d id %0d amount %0d",
							$realtime, got.kind, got.id, got.amt);
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display({"%0t: mismatch kind %0d/%0d id %0d/%0d amount %0d/%0d ",
								"best %0d/%0d last %0d/%0d (expected/actual)"}, $realtime,
								want.kind, got.kind, want.id, got.id, want.amt, got.amt,
								want.best, got.best, want.last, got.last);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_CLUSTERS) clusters_reg = cfg_data;
				else if (cfg_index == REG_LENGTH) length_reg = cfg_data;
			end
			if (in_valid && in_ready)
				predict_word(action, cluster_sel, dim_sel, sample, last_element);
		end
	end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the k-means engine
// Loads centers, streams training and classify frames and end-of-pass words
// under several cluster and length settings, with bursty input and a stalling
// output side. The checker module does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import kmauc_pkg::*;

	logic clk, arst_n;
	logic in_valid, in_ready, last_element;
	logic [1:0] action;
	logic [3:0] cluster_sel, dim_sel;
	logic [15:0] sample;
	logic out_valid, out_ready, last_result;
	logic [1:0] result_kind;
	logic [3:0] cluster_id, best_cluster;
	logic [23:0] amount;
	logic cfg_valid, cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0] cfg_data;
	int errors, pending, words_seen;

	int burst_left = 0;
	int words_sent = 0;
	int hold_req = 0, hold_seen = 0, hold_cnt = 0;
	int nd_now = 1, nc_now = 1;
	int passes = 0, frames = 0;

	kmeans_assign_update_classify i_dut (.*);

	kmauc_checker i_checker (.*);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Receiver: long hold-offs on request, otherwise its own stall pattern.
	initial begin
		int mode;
		mode = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_cnt = 400;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready = 1'b0;
			end else begin
				if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
				case (mode)
					0: out_ready = 1'b1;
					1: out_ready = ($urandom_range(0, 3) != 0);
					default: out_ready = ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Generous fixed limit on the whole run.
	initial begin
		#40_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2, 3: return 16'($signed($urandom_range(0, 2047)) - 1024);
			default: return 16'($urandom);
		endcase
	endfunction

	// Offer one input word and wait for it to be taken.
	task automatic put_word(logic [1:0] act, logic [3:0] cs, logic [3:0] ds,
			logic [15:0] smp, logic lst);
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
		end
		in_valid = 1'b1;
		action = act;
		cluster_sel = cs;
		dim_sel = ds;
		sample = smp;
		last_element = lst;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		words_sent++;
		burst_left--;
		if (burst_left == 0) in_valid = 1'b0;
	endtask

	// Stream one frame; the action of the last element decides its kind.
	task automatic put_frame(logic [1:0] act, int len, bit mixed);
		logic [1:0] a;
		for (int i = 0; i < len; i++) begin
			a = act;
			if (mixed && i + 1 < len) a = $urandom_range(0, 1) ? ACT_TRAIN : ACT_CLASS;
			put_word(a, 4'($urandom), 4'($urandom), pick_sample(), i + 1 == len);
		end
		frames++;
	endtask

	task automatic end_pass();
		put_word(ACT_PASS, 4'($urandom), 4'($urandom), 16'($urandom), 1'($urandom));
		passes++;
	endtask

	// Let all results drain and the back end settle before touching registers.
	task automatic settle();
		in_valid = 1'b0;
		burst_left = 0;
		while (pending != 0) @(posedge clk);
		repeat (6000) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_shape(int nc, int nd);
		settle();
		write_reg(REG_CLUSTERS, 5'(nc));
		write_reg(REG_LENGTH, 5'(nd));
		nc_now = (nc < 1) ? 1 : (nc > 16) ? 16 : nc;
		nd_now = (nd < 1) ? 1 : (nd > 16) ? 16 : nd;
	endtask

	initial begin
		int r, len;
		in_valid = 1'b0;
		action = ACT_LOAD;
		cluster_sel = '0;
		dim_sel = '0;
		sample = '0;
		last_element = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_CLUSTERS;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed words at the reset shape of one cluster and one dimension.
		put_word(ACT_LOAD, 4'd0, 4'd0, 16'h8000, 1'b0);
		put_word(ACT_TRAIN, 4'd0, 4'd0, 16'h7FFF, 1'b1);
		put_word(ACT_CLASS, 4'd0, 4'd0, 16'h8000, 1'b1);
		end_pass();

		// Full shape: extremes, a long frame, a short one, a mixed one.
		set_shape(16, 16);
		put_word(ACT_LOAD, 4'd15, 4'd15, 16'h7FFF, 1'b1);
		put_word(ACT_LOAD, 4'd5, 4'd10, 16'h0100, 1'b0);
		put_word(ACT_LOAD, 4'd10, 4'd5, 16'hFF00, 1'b0);
		put_frame(ACT_TRAIN, 18, 1'b0);
		put_frame(ACT_TRAIN, 3, 1'b0);
		put_frame(ACT_CLASS, 5, 1'b1);
		// A frame cut short by a center load, then an all-zero frame with a tie.
		put_word(ACT_TRAIN, 4'd0, 4'd0, 16'h1234, 1'b0);
		put_word(ACT_LOAD, 4'd1, 4'd0, 16'h0000, 1'b0);
		put_word(ACT_CLASS, 4'd0, 4'd0, 16'h0000, 1'b1);
		// A frame cut short by an end of pass.
		put_word(ACT_CLASS, 4'd0, 4'd0, 16'h0042, 1'b0);
		end_pass();
		put_frame(ACT_CLASS, 16, 1'b0);

		// Out-of-range register values and the unused register index.
		settle();
		write_reg(2'd3, 5'd31);
		set_shape(0, 31);
		put_frame(ACT_TRAIN, 16, 1'b0);
		end_pass();
		set_shape(31, 0);
		put_frame(ACT_CLASS, 1, 1'b0);
		end_pass();
		set_shape(3, 4);

		// Long output hold-off while frames keep arriving.
		hold_req++;
		put_frame(ACT_CLASS, 4, 1'b0);
		put_frame(ACT_CLASS, 2, 1'b0);
		put_frame(ACT_TRAIN, 4, 1'b0);
		put_frame(ACT_CLASS, 4, 1'b0);

		// Random sequences, mostly well formed, reshaped now and then.
		while (words_sent < 150) begin
			if (words_sent % 50 < 2 && $urandom_range(0, 1) == 0)
				set_shape($urandom_range(1, 16), ($urandom_range(0, 3) == 0) ?
					$urandom_range(9, 16) : $urandom_range(1, 6));
			r = $urandom_range(0, 99);
			if (r < 12) begin
				put_word(ACT_LOAD, 4'($urandom_range(0, nc_now - 1)),
					4'($urandom_range(0, nd_now - 1)), pick_sample(), 1'($urandom));
			end else if (r < 15) begin
				put_word(ACT_LOAD, 4'($urandom), 4'($urandom), pick_sample(), 1'($urandom));
			end else if (r < 22) begin
				end_pass();
			end else if (r < 27) begin
				len = $urandom_range(1, nd_now);
				for (int i = 0; i < len; i++)
					put_word($urandom_range(0, 1) ? ACT_TRAIN : ACT_CLASS, 4'($urandom),
						4'($urandom), pick_sample(), 1'b0);
			end else begin
				case ($urandom_range(0, 9))
					0: len = $urandom_range(1, nd_now);
					1: len = nd_now + $urandom_range(1, 3);
					default: len = nd_now;
				endcase
				put_frame(($urandom_range(0, 9) < 6) ? ACT_TRAIN : ACT_CLASS, len,
					$urandom_range(0, 9) == 0);
			end
		end
		end_pass();

		in_valid = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("Sent %0d input words: %0d frames and %0d ends of pass.",
			words_sent, frames, passes);
		$display("Checked %0d output words across several cluster and length settings.",
			words_seen);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
